>>> hdl/assert_macros.svh
// assertion macros used by the decoder top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define GLZW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define GLZW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GLZW_ASSERT(lbl, prop, msg)
`define GLZW_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hdl/glzw_pkg.sv
// constants and helpers for the gif lzw decoder
`default_nettype none
package glzw_pkg;
  localparam int TableEntries = 4096;
  localparam int MaxCodeBits  = 12;
  localparam int ResBits      = 24;

  localparam logic [2:0] ST_PIXEL   = 3'd0;
  localparam logic [2:0] ST_NEED    = 3'd1;
  localparam logic [2:0] ST_END_PAD = 3'd2;
  localparam logic [2:0] ST_BYTE_OK = 3'd3;
  localparam logic [2:0] ST_DROPPED = 3'd4;

  localparam logic MODE_BYTE  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  // saturate the minimum code size to 2..8
  function automatic logic [3:0] eff_size(input logic [3:0] raw);
    if (raw < 4'd2) return 4'd2;
    if (raw > 4'd8) return 4'd8;
    return raw;
  endfunction
endpackage
`default_nettype wire

>>> hdl/glzw_in_if.sv
// input channel: one data byte or one pixel request per word
`default_nettype none
interface glzw_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface
`default_nettype wire

>>> hdl/glzw_out_if.sv
// output channel: one result word
`default_nettype none
interface glzw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic [2:0] status;
  logic       bad_data;
  modport source (output valid, output pixel, output status, output bad_data, input ready);
  modport sink (input valid, input pixel, input status, input bad_data, output ready);
endinterface
`default_nettype wire

>>> hdl/glzw_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module glzw_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> hdl/gif_lzw_decoder_top.sv
// gif lzw decoder top level: byte framing, code reader, table walk sequencer
//
// channel  dir  handshake      word
// in_i     in   valid/ready    mode, data_byte
// out_o    out  valid/ready    pixel, status, bad_data
// cfg      in   cfg_we_i       initial_code_size (cfg_wdata_i)
//
// a data byte is handled in idle; a stacked pixel goes through idle and pop
// a code read goes from idle to fetch, staying in fetch for each clear code swallowed; a code
// that expands through the table then passes rd and wait once per table entry walked
// the walk is bounded by the chain length in the table
// ready only in idle with the output slot free or draining
// reset and a config write both restart the decoder; the tables need no clearing
`default_nettype none
`include "assert_macros.svh"
module gif_lzw_decoder_top #(
  parameter int TABLE_ENTRIES = glzw_pkg::TableEntries,
  parameter int MAX_CODE_BITS = glzw_pkg::MaxCodeBits
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_wdata_i,
  glzw_in_if.sink         in_i,
  glzw_out_if.source      out_o
);
  localparam int AW = $clog2(TABLE_ENTRIES);
  // common width for codes, table counts and compares
  localparam int NW = (AW + 1 > MAX_CODE_BITS) ? AW + 1 : MAX_CODE_BITS;
  localparam int RB = glzw_pkg::ResBits;
  localparam logic [NW-1:0] TBL = NW'(TABLE_ENTRIES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POP   = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [3:0]             size_q, size_d;
  logic [AW:0]            depth_q, depth_d;
  logic [3:0]             cw_q, cw_d;
  logic [NW-1:0]          nfc_q, nfc_d;
  logic [MAX_CODE_BITS-1:0] prev_q, prev_d;
  logic [7:0]             first_q, first_d;
  logic                   await_q, await_d;
  logic [RB-1:0]          res_q, res_d;
  logic [4:0]             bits_q, bits_d;
  logic [7:0]             left_q, left_d;
  logic                   fin_q, fin_d;
  logic                   end_q, end_d;
  logic [NW-1:0]          cur_q, cur_d;
  logic [MAX_CODE_BITS-1:0] incode_q, incode_d;
  logic                   bad_q, bad_d;

  logic       ovld_q, ovld_d;
  logic [7:0] opix_q, opix_d;
  logic [2:0] ost_q, ost_d;
  logic       obad_q, obad_d;

  // ram ports
  logic                     stk_we;
  logic [AW-1:0]            stk_waddr, stk_raddr;
  logic [7:0]               stk_wdata, stk_rdata;
  logic                     tbl_we;
  logic [AW-1:0]            tbl_waddr, tbl_raddr;
  logic [MAX_CODE_BITS-1:0] head_rdata;
  logic [7:0]               tail_rdata;

  // derived values
  logic [3:0]    esize;
  logic [NW-1:0] clr;
  logic [RB-1:0] cmask;
  logic [NW-1:0] fcode;
  logic          have_bits;
  logic          walk_go;
  logic [NW-1:0] fin_code;
  logic [NW-1:0] nfc_inc;
  logic          accept;
  logic [3:0]    new_size;

  assign esize     = glzw_pkg::eff_size(size_q);
  assign clr       = NW'(1) << esize;
  assign cmask     = ~({RB{1'b1}} << cw_q);
  assign fcode     = NW'(res_q[MAX_CODE_BITS-1:0] & cmask[MAX_CODE_BITS-1:0]);
  assign have_bits = {1'b0, bits_q} >= {2'b00, cw_q};
  assign walk_go   = (cur_q >= clr) && (cur_q < TBL) && (depth_q < (AW+1)'(TABLE_ENTRIES));
  assign fin_code  = (cur_q >= clr) ? '0 : cur_q;
  assign nfc_inc   = nfc_q + NW'(1);
  assign accept    = in_i.valid && in_i.ready;
  assign new_size  = glzw_pkg::eff_size(cfg_wdata_i);

  assign in_i.ready = (state_q == S_IDLE) && (!ovld_q || out_o.ready);

  assign stk_raddr = AW'(depth_q - (AW+1)'(1));
  assign stk_waddr = depth_q[AW-1:0];
  assign tbl_raddr = cur_q[AW-1:0];
  assign tbl_waddr = nfc_q[AW-1:0];

  always_comb begin
    state_d  = state_q;
    size_d   = size_q;
    depth_d  = depth_q;
    cw_d     = cw_q;
    nfc_d    = nfc_q;
    prev_d   = prev_q;
    first_d  = first_q;
    await_d  = await_q;
    res_d    = res_q;
    bits_d   = bits_q;
    left_d   = left_q;
    fin_d    = fin_q;
    end_d    = end_q;
    cur_d    = cur_q;
    incode_d = incode_q;
    bad_d    = bad_q;
    ovld_d   = ovld_q && !out_o.ready;
    opix_d   = opix_q;
    ost_d    = ost_q;
    obad_d   = obad_q;
    stk_we    = 1'b0;
    stk_wdata = first_q;
    tbl_we    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          opix_d = '0;
          obad_d = 1'b0;
          if (in_i.mode == glzw_pkg::MODE_BYTE) begin
            ovld_d = 1'b1;
            ost_d  = glzw_pkg::ST_BYTE_OK;
            // sub-block framing, then reservoir packing lsb first
            if (fin_q) begin
              ost_d = glzw_pkg::ST_DROPPED;
            end else if (left_q == '0) begin
              if (in_i.data_byte == '0) begin
                fin_d = 1'b1;
              end else begin
                left_d = in_i.data_byte;
              end
            end else begin
              left_d = left_q - 8'd1;
              if (!end_q) begin
                if (bits_q > 5'd16) begin
                  ost_d = glzw_pkg::ST_DROPPED;
                end else begin
                  res_d  = res_q | (RB'(in_i.data_byte) << bits_q);
                  bits_d = bits_q + 5'd8;
                end
              end
            end
          end else if (depth_q != '0) begin
            depth_d = depth_q - (AW+1)'(1);
            state_d = S_POP;
          end else if (end_q) begin
            ovld_d = 1'b1;
            ost_d  = glzw_pkg::ST_END_PAD;
          end else begin
            bad_d   = 1'b0;
            state_d = S_FETCH;
          end
        end
      end
      S_POP: begin
        ovld_d  = 1'b1;
        opix_d  = stk_rdata;
        ost_d   = glzw_pkg::ST_PIXEL;
        state_d = S_IDLE;
      end
      S_FETCH: begin
        if (!have_bits && !fin_q) begin
          ovld_d  = 1'b1;
          ost_d   = glzw_pkg::ST_NEED;
          state_d = S_IDLE;
        end else begin
          cur_d = have_bits ? fcode : clr + NW'(1);
          if (have_bits) begin
            res_d  = res_q >> cw_q;
            bits_d = bits_q - {1'b0, cw_q};
          end
          if (cur_d == clr) begin
            // clear code: restart table and width, read another code
            cw_d    = esize + 4'd1;
            nfc_d   = clr + NW'(2);
            depth_d = '0;
            await_d = 1'b1;
          end else if (await_q) begin
            await_d = 1'b0;
            if (cur_d > clr) begin
              cur_d  = '0;
              obad_d = 1'b1;
            end else begin
              obad_d = 1'b0;
            end
            first_d = cur_d[7:0];
            prev_d  = MAX_CODE_BITS'(cur_d);
            ovld_d  = 1'b1;
            opix_d  = cur_d[7:0];
            ost_d   = glzw_pkg::ST_PIXEL;
            state_d = S_IDLE;
          end else if (cur_d == clr + NW'(1)) begin
            end_d   = 1'b1;
            res_d   = '0;
            bits_d  = '0;
            ovld_d  = 1'b1;
            opix_d  = '0;
            obad_d  = 1'b0;
            ost_d   = glzw_pkg::ST_END_PAD;
            state_d = S_IDLE;
          end else begin
            incode_d = MAX_CODE_BITS'(cur_d);
            if (cur_d >= nfc_q) begin
              // code not yet in the table: previous string plus its first byte
              if (cur_d > nfc_q) begin
                incode_d = '0;
                bad_d    = 1'b1;
              end
              stk_we    = 1'b1;
              stk_wdata = first_q;
              depth_d   = depth_q + (AW+1)'(1);
              cur_d     = NW'(prev_q);
            end
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        if (walk_go) begin
          state_d = S_WAIT;
        end else begin
          first_d = fin_code[7:0];
          if (nfc_q < TBL) begin
            tbl_we = 1'b1;
            nfc_d  = nfc_inc;
            if (((nfc_inc >> cw_q) != '0) && ({28'd0, cw_q} < MAX_CODE_BITS)) begin
              cw_d = cw_q + 4'd1;
            end
          end
          prev_d  = incode_q;
          ovld_d  = 1'b1;
          opix_d  = fin_code[7:0];
          ost_d   = glzw_pkg::ST_PIXEL;
          obad_d  = bad_q;
          state_d = S_IDLE;
        end
      end
      S_WAIT: begin
        stk_we    = 1'b1;
        stk_wdata = tail_rdata;
        depth_d   = depth_q + (AW+1)'(1);
        cur_d     = NW'(head_rdata);
        state_d   = S_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // config write restarts the code reader, framing and table; fsm state and output word are kept
    if (cfg_we_i) begin
      size_d  = cfg_wdata_i;
      cw_d    = new_size + 4'd1;
      nfc_d   = (NW'(1) << new_size) + NW'(2);
      depth_d = '0;
      prev_d  = '0;
      first_d = '0;
      await_d = 1'b1;
      res_d   = '0;
      bits_d  = '0;
      left_d  = '0;
      fin_d   = 1'b0;
      end_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      size_q  <= 4'd8;
      depth_q <= '0;
      cw_q    <= 4'd9;
      nfc_q   <= NW'(258);
      prev_q  <= '0;
      first_q <= '0;
      await_q <= 1'b1;
      res_q   <= '0;
      bits_q  <= '0;
      left_q  <= '0;
      fin_q   <= 1'b0;
      end_q   <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
      depth_q <= depth_d;
      cw_q    <= cw_d;
      nfc_q   <= nfc_d;
      prev_q  <= prev_d;
      first_q <= first_d;
      await_q <= await_d;
      res_q   <= res_d;
      bits_q  <= bits_d;
      left_q  <= left_d;
      fin_q   <= fin_d;
      end_q   <= end_d;
      ovld_q  <= ovld_d;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    incode_q <= incode_d;
    bad_q    <= bad_d;
    opix_q   <= opix_d;
    ost_q    <= ost_d;
    obad_q   <= obad_d;
  end

  assign out_o.valid    = ovld_q;
  assign out_o.pixel    = opix_q;
  assign out_o.status   = ost_q;
  assign out_o.bad_data = obad_q;

  glzw_ram #(.Width(8), .Depth(TABLE_ENTRIES)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  glzw_ram #(.Width(MAX_CODE_BITS), .Depth(TABLE_ENTRIES)) u_head (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (prev_q),
    .raddr_i (tbl_raddr),
    .rdata_o (head_rdata)
  );

  glzw_ram #(.Width(8), .Depth(TABLE_ENTRIES)) u_tail (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (first_d),
    .raddr_i (tbl_raddr),
    .rdata_o (tail_rdata)
  );

  `GLZW_ASSERT(a_busy_not_ready, (state_q != S_IDLE) |-> !in_i.ready, "ready while busy")
  `GLZW_ASSERT(a_res_bits, bits_q <= 5'd24, "reservoir overfilled")
  `GLZW_ASSERT(a_depth, depth_q <= (AW+1)'(TABLE_ENTRIES), "stack overflow")
  `GLZW_ASSERT(a_width, (cw_q >= 4'd3) && ({28'd0, cw_q} <= MAX_CODE_BITS), "bad code width")
  `GLZW_ASSERT(a_pop_emits, (state_q == S_POP) |=> out_o.valid, "pop gave no word")
  `GLZW_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (state_q == S_IDLE), "not idle in reset")
endmodule
`default_nettype wire
